@@ sv/lcd4seq_pkg.sv @@
// ---------------------------------------------------------------------------
// lcd4seq_pkg
// Shared types, codes and the microcode table of the 4-bit LCD write
// sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package lcd4seq_pkg;

  // request kinds
  typedef enum logic [2:0] {
    CMD_NIBBLE = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_INIT   = 3'd4
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE_PULSE = 2'd0,
    REG_CHAR_WAIT    = 2'd1,
    REG_CURSOR_WAIT  = 2'd2
  } reg_idx_t;

  localparam int unsigned ROM_DEPTH = 33;
  localparam int unsigned PC_W      = $clog2(ROM_DEPTH);

  // program entry points
  localparam logic [PC_W-1:0] ENTRY_BYTE   = PC_W'(0);
  localparam logic [PC_W-1:0] ENTRY_NIBBLE = PC_W'(2);
  localparam logic [PC_W-1:0] ENTRY_INIT   = PC_W'(4);

  localparam logic [7:0]  CURSOR_BASE       = 8'h80;
  localparam logic [7:0]  ENABLE_PULSE_RST  = 8'd1;
  localparam logic [15:0] CHAR_WAIT_RST     = 16'd46;
  localparam logic [15:0] CURSOR_WAIT_RST   = 16'd53;
  localparam logic [15:0] POWER_ON_WAIT_US  = 16'd15000;
  localparam logic [15:0] FIRST_NIB_WAIT_US = 16'd4300;
  localparam logic [15:0] NIB_WAIT_US       = 16'd150;
  localparam logic [15:0] BYTE_WAIT_US      = 16'd70;
  localparam logic [15:0] CLEAR_WAIT_US     = 16'd5000;

  typedef enum logic [1:0] {
    NIB_HIGH  = 2'd0,
    NIB_LOW   = 2'd1,
    NIB_CONST = 2'd2
  } nib_sel_t;

  typedef enum logic [1:0] {
    HOLD_PULSE = 2'd0,
    HOLD_ZERO  = 2'd1,
    HOLD_WAIT  = 2'd2,
    HOLD_CONST = 2'd3
  } hold_sel_t;

  // one control word per phase
  typedef struct packed {
    nib_sel_t    nib_sel;
    logic [3:0]  const_nib;
    logic        rs_use;
    logic        en;
    hold_sel_t   hold_sel;
    logic [15:0] const_hold;
    logic        last;
  } cw_t;

  // sequencer to datapath control
  typedef struct packed {
    logic            load;
    logic            step;
    cw_t             cw;
    logic [PC_W-1:0] pc;
  } ctrl_t;

  function automatic cw_t mk_cw(nib_sel_t nsel, logic [3:0] cnib, logic rs, logic en,
                                hold_sel_t hsel, logic [15:0] chold, logic last);
    cw_t w;
    w.nib_sel    = nsel;
    w.const_nib  = cnib;
    w.rs_use     = rs;
    w.en         = en;
    w.hold_sel   = hsel;
    w.const_hold = chold;
    w.last       = last;
    return w;
  endfunction

  // microcode: byte routine at 0..3 (nibble entry at 2), init at 4..32
  function automatic cw_t rom_word(logic [PC_W-1:0] addr);
    cw_t w;
    unique case (addr)
      6'd0:  w = mk_cw(NIB_HIGH,  4'h0, 1'b1, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd1:  w = mk_cw(NIB_HIGH,  4'h0, 1'b1, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd2:  w = mk_cw(NIB_LOW,   4'h0, 1'b1, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd3:  w = mk_cw(NIB_LOW,   4'h0, 1'b1, 1'b0, HOLD_WAIT,  16'd0, 1'b1);
      6'd4:  w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_CONST, POWER_ON_WAIT_US, 1'b0);
      6'd5:  w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd6:  w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_CONST, FIRST_NIB_WAIT_US, 1'b0);
      6'd7:  w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd8:  w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_CONST, NIB_WAIT_US, 1'b0);
      6'd9:  w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd10: w = mk_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_CONST, NIB_WAIT_US, 1'b0);
      6'd11: w = mk_cw(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd12: w = mk_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_CONST, NIB_WAIT_US, 1'b0);
      // function set 0x28
      6'd13: w = mk_cw(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd14: w = mk_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd15: w = mk_cw(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd16: w = mk_cw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_CONST, BYTE_WAIT_US, 1'b0);
      // display off 0x08
      6'd17: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd18: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd19: w = mk_cw(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd20: w = mk_cw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_CONST, BYTE_WAIT_US, 1'b0);
      // clear 0x01
      6'd21: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd22: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd23: w = mk_cw(NIB_CONST, 4'h1, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd24: w = mk_cw(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_CONST, CLEAR_WAIT_US, 1'b0);
      // entry mode 0x06
      6'd25: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd26: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd27: w = mk_cw(NIB_CONST, 4'h6, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd28: w = mk_cw(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_CONST, BYTE_WAIT_US, 1'b0);
      // display on 0x0F
      6'd29: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd30: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO,  16'd0, 1'b0);
      6'd31: w = mk_cw(NIB_CONST, 4'hF, 1'b0, 1'b1, HOLD_PULSE, 16'd0, 1'b0);
      6'd32: w = mk_cw(NIB_CONST, 4'hF, 1'b0, 1'b0, HOLD_CONST, BYTE_WAIT_US, 1'b1);
      default: w = mk_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO, 16'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/lcd4seq_seq.sv @@
// ---------------------------------------------------------------------------
// lcd4seq_seq
// Step counter and microcode fetch: dispatches a request to its entry
// point and walks the table one phase per free output slot.
// ---------------------------------------------------------------------------
`default_nettype none

module lcd4seq_seq
  import lcd4seq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ctrl_t           ctrl
);

  logic            busy;
  logic [PC_W-1:0] pc;
  logic            accept;
  logic            step;
  logic            entry_ok;
  logic [PC_W-1:0] entry_pc;
  cw_t             cw;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign step     = busy && (!out_valid || out_ready);
  assign cw       = rom_word(pc);

  // entry dispatch by request kind
  always_comb begin
    entry_ok = 1'b1;
    entry_pc = ENTRY_BYTE;
    case (command)
      CMD_NIBBLE: entry_pc = ENTRY_NIBBLE;
      CMD_BYTE, CMD_CHAR, CMD_CURSOR: entry_pc = ENTRY_BYTE;
      CMD_INIT: entry_pc = ENTRY_INIT;
      default: entry_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= ENTRY_BYTE;
      out_valid <= 1'b0;
    end else begin
      if (accept && entry_ok) begin
        busy <= 1'b1;
        pc   <= entry_pc;
      end else if (step) begin
        if (cw.last) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ctrl.load = accept;
  assign ctrl.step = step;
  assign ctrl.cw   = cw;
  assign ctrl.pc   = pc;

endmodule

`default_nettype wire

@@ sv/lcd4seq_dp.sv @@
// ---------------------------------------------------------------------------
// lcd4seq_dp
// Datapath: configuration registers, request operand latch and the
// phase output register driven by the current control word.
// ---------------------------------------------------------------------------
`default_nettype none

module lcd4seq_dp
  import lcd4seq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire ctrl_t       ctrl,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  value,
  input  wire logic        row,
  input  wire logic [5:0]  column,
  input  wire logic [15:0] wait_us,
  output logic [3:0]       data_nibble,
  output logic             register_select,
  output logic             enable,
  output logic [15:0]      hold_us,
  output logic             last
);

  logic [7:0]  pulse_us;
  logic [15:0] char_wait;
  logic [15:0] cursor_wait;
  logic [7:0]  op_byte;
  logic        op_rs;
  logic [15:0] op_wait;
  logic [7:0]  op_byte_next;
  logic        op_rs_next;
  logic [15:0] op_wait_next;
  logic [3:0]  nib_next;
  logic [15:0] hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_us    <= ENABLE_PULSE_RST;
      char_wait   <= CHAR_WAIT_RST;
      cursor_wait <= CURSOR_WAIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE_PULSE: pulse_us    <= cfg_data[7:0];
        REG_CHAR_WAIT:    char_wait   <= cfg_data;
        REG_CURSOR_WAIT:  cursor_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand for the byte routine
  always_comb begin
    op_byte_next = value;
    op_rs_next   = 1'b0;
    op_wait_next = wait_us;
    case (command)
      CMD_NIBBLE: op_byte_next = {4'h0, value[3:0]};
      CMD_CHAR: begin
        op_rs_next   = 1'b1;
        op_wait_next = char_wait;
      end
      CMD_CURSOR: begin
        op_byte_next = CURSOR_BASE | {1'b0, row, column};
        op_wait_next = cursor_wait;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_byte <= op_byte_next;
      op_rs   <= op_rs_next;
      op_wait <= op_wait_next;
    end
  end

  always_comb begin
    unique case (ctrl.cw.nib_sel)
      NIB_HIGH:  nib_next = op_byte[7:4];
      NIB_LOW:   nib_next = op_byte[3:0];
      NIB_CONST: nib_next = ctrl.cw.const_nib;
      default:   nib_next = ctrl.cw.const_nib;
    endcase
    unique case (ctrl.cw.hold_sel)
      HOLD_PULSE: hold_next = {8'h00, pulse_us};
      HOLD_ZERO:  hold_next = 16'd0;
      HOLD_WAIT:  hold_next = op_wait;
      HOLD_CONST: hold_next = ctrl.cw.const_hold;
      default:    hold_next = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      data_nibble     <= nib_next;
      register_select <= ctrl.cw.rs_use && op_rs;
      enable          <= ctrl.cw.en;
      hold_us         <= hold_next;
      last            <= ctrl.cw.last;
    end
  end

endmodule

`default_nettype wire

@@ sv/char_lcd_four_bit_write_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// char_lcd_four_bit_write_sequencer_core
// Turns one LCD request into the pin phases of a 4-bit character LCD bus.
// ---------------------------------------------------------------------------
// start: the request loads the step counter, then its first phase enters the
//   output register, then one phase per cycle while out_ready is high
// phases: n per request (2 nibble, 4 byte, char or cursor, 29 init), set by
//   the single step counter walking the microcode, one request at a time
// reset: synchronous; registers return to 1 / 46 / 53 us, sequencer idle
`default_nettype none

module char_lcd_four_bit_write_sequencer_core
  import lcd4seq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  value,
  input  wire logic        row,
  input  wire logic [5:0]  column,
  input  wire logic [15:0] wait_us,
  // phase channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       data_nibble,
  output logic             register_select,
  output logic             enable,
  output logic [15:0]      hold_us,
  output logic             last
);

  ctrl_t ctrl;

  // step counter and microcode table; a new request is taken as soon as
  // the final phase of the previous one is in the output register
  lcd4seq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // operand latch, settings and the phase output register
  lcd4seq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctrl            (ctrl),
    .command         (command),
    .value           (value),
    .row             (row),
    .column          (column),
    .wait_us         (wait_us),
    .data_nibble     (data_nibble),
    .register_select (register_select),
    .enable          (enable),
    .hold_us         (hold_us),
    .last            (last)
  );

  // an init transaction must keep the sequencer busy
  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_INIT) |=> !in_ready)
    else $error("init request did not start the sequencer");

  // every request ends on an enable-low phase
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !enable)
    else $error("final phase has enable high");

  // step counter stays inside the microcode table
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (ctrl.pc < PC_W'(ROM_DEPTH)))
    else $error("step counter outside microcode table");

  // a phase is only written into a free output slot
  a_step_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> (!out_valid || out_ready))
    else $error("phase overwrote a pending transaction");

endmodule

`default_nettype wire

@@ sim/lcd_phase_checker.sv @@
// ---------------------------------------------------------------------------
// lcd_phase_checker
// Watches the register port and both channels of the 4-bit LCD write
// sequencer, works out the pin phases of every accepted request and
// compares each phase the block hands out against the oldest one waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_phase_checker
  import lcd4seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  value,
  input  logic        row,
  input  logic [5:0]  column,
  input  logic [15:0] wait_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  data_nibble,
  input  logic        register_select,
  input  logic        enable,
  input  logic [15:0] hold_us,
  input  logic        last,
  output int          mismatch_count,
  output int          phases_outstanding
);

  typedef struct packed {
    logic [3:0]  nib;
    logic        rs;
    logic        en;
    logic [15:0] hold;
    logic        is_last;
  } lcd_phase_t;

  lcd_phase_t  expected_phases[$];
  logic [7:0]  pulse_us;
  logic [15:0] char_wait;
  logic [15:0] cursor_wait;
  int          mismatches;

  function automatic void add_phase(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
    lcd_phase_t p;
    p.nib     = nib;
    p.rs      = rs;
    p.en      = en;
    p.hold    = hold;
    p.is_last = 1'b0;
    expected_phases.push_back(p);
  endfunction

  // enable-high pulse then enable-low holding the wait
  function automatic void add_nibble(logic [3:0] nib, logic rs, logic [15:0] hold);
    add_phase(nib, rs, 1'b1, {8'h00, pulse_us});
    add_phase(nib, rs, 1'b0, hold);
  endfunction

  // high nibble first, no wait between the two nibbles
  function automatic void add_byte(logic [7:0] data, logic rs, logic [15:0] hold);
    add_nibble(data[7:4], rs, 16'd0);
    add_nibble(data[3:0], rs, hold);
  endfunction

  function automatic void predict_request(logic [2:0] cmd, logic [7:0] val, logic r,
                                          logic [5:0] col, logic [15:0] wt);
    int         depth_before;
    lcd_phase_t tail;
    depth_before = expected_phases.size();
    case (cmd)
      CMD_NIBBLE: add_nibble(val[3:0], 1'b0, wt);
      CMD_BYTE:   add_byte(val, 1'b0, wt);
      CMD_CHAR:   add_byte(val, 1'b1, char_wait);
      CMD_CURSOR: add_byte(CURSOR_BASE | {1'b0, r, col}, 1'b0, cursor_wait);
      CMD_INIT: begin
        add_phase(4'h0, 1'b0, 1'b0, POWER_ON_WAIT_US);
        add_nibble(4'h3, 1'b0, FIRST_NIB_WAIT_US);
        add_nibble(4'h3, 1'b0, NIB_WAIT_US);
        add_nibble(4'h3, 1'b0, NIB_WAIT_US);
        add_nibble(4'h2, 1'b0, NIB_WAIT_US);
        add_byte(8'h28, 1'b0, BYTE_WAIT_US);
        add_byte(8'h08, 1'b0, BYTE_WAIT_US);
        add_byte(8'h01, 1'b0, CLEAR_WAIT_US);
        add_byte(8'h06, 1'b0, BYTE_WAIT_US);
        add_byte(8'h0F, 1'b0, BYTE_WAIT_US);
      end
      default: ;
    endcase
    if (expected_phases.size() > depth_before) begin
      tail = expected_phases.pop_back();
      tail.is_last = 1'b1;
      expected_phases.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    lcd_phase_t want;
    if (rst) begin
      expected_phases.delete();
      pulse_us    = ENABLE_PULSE_RST;
      char_wait   = CHAR_WAIT_RST;
      cursor_wait = CURSOR_WAIT_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLE_PULSE: pulse_us    = cfg_data[7:0];
          REG_CHAR_WAIT:    char_wait   = cfg_data;
          REG_CURSOR_WAIT:  cursor_wait = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_phases.size() == 0) begin
          $error("unexpected phase: nibble %0h rs %0b en %0b hold %0d last %0b",
                 data_nibble, register_select, enable, hold_us, last);
          mismatches++;
        end else begin
          want = expected_phases.pop_front();
          if (data_nibble !== want.nib) begin
            $error("data_nibble: expected %0h, actual %0h", want.nib, data_nibble);
            mismatches++;
          end
          if (register_select !== want.rs) begin
            $error("register_select: expected %0b, actual %0b", want.rs, register_select);
            mismatches++;
          end
          if (enable !== want.en) begin
            $error("enable: expected %0b, actual %0b", want.en, enable);
            mismatches++;
          end
          if (hold_us !== want.hold) begin
            $error("hold_us: expected %0d, actual %0d", want.hold, hold_us);
            mismatches++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_request(command, value, row, column, wait_us);
    end
    mismatch_count     <= mismatches;
    phases_outstanding <= expected_phases.size();
  end

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Drives the 4-bit LCD write sequencer with directed and random requests
// under several register settings, with random gaps and back-pressure on
// both channels; the phase checker beside the block does the comparing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import lcd4seq_pkg::*;
;

  // quiet cycles before a register write, covers ignored request codes
  localparam int SETTLE_CYCLES   = 40;
  // long receiver hold-off, enough to back the block up into the sender
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 25;

  logic        clk;
  logic        rst             = 1'b1;
  logic        cfg_write       = 1'b0;
  logic [1:0]  cfg_index       = 2'd0;
  logic [15:0] cfg_data        = 16'd0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [2:0]  command         = 3'd0;
  logic [7:0]  value           = 8'd0;
  logic        row             = 1'b0;
  logic [5:0]  column          = 6'd0;
  logic [15:0] wait_us         = 16'd0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [3:0]  data_nibble;
  logic        register_select;
  logic        enable;
  logic [15:0] hold_us;
  logic        last;

  int mismatch_count;
  int phases_outstanding;

  // idling switches for each side, and the hold-off request to the receiver
  bit tx_idle_on      = 1'b1;
  bit rx_idle_on      = 1'b1;
  bit hold_off_wanted = 1'b0;

  char_lcd_four_bit_write_sequencer_core uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .value           (value),
    .row             (row),
    .column          (column),
    .wait_us         (wait_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_nibble     (data_nibble),
    .register_select (register_select),
    .enable          (enable),
    .hold_us         (hold_us),
    .last            (last)
  );

  lcd_phase_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .value              (value),
    .row                (row),
    .column             (column),
    .wait_us            (wait_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .data_nibble        (data_nibble),
    .register_select    (register_select),
    .enable             (enable),
    .hold_us            (hold_us),
    .last               (last),
    .mismatch_count     (mismatch_count),
    .phases_outstanding (phases_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offers one request and returns at the edge that accepts it; valid stays
  // high so a following request can go straight out in the same step
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] val, input logic r,
                              input logic [5:0] col, input logic [15:0] wt);
    if (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (tx_idle_on && $urandom_range(99) < 16);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    row      <= r;
    column   <= col;
    wait_us  <= wt;
    do @(posedge clk); while (!in_ready);
  endtask

  // random request, mostly real kinds with the odd unused code as noise
  task automatic send_random_request(output bit counted);
    int          pick;
    logic [2:0]  cmd;
    logic [15:0] wt;
    pick = $urandom_range(99);
    if (pick < 22)      cmd = CMD_NIBBLE;
    else if (pick < 44) cmd = CMD_BYTE;
    else if (pick < 66) cmd = CMD_CHAR;
    else if (pick < 88) cmd = CMD_CURSOR;
    else if (pick < 94) cmd = CMD_INIT;
    else                cmd = 3'($urandom_range(7, 5));
    pick = $urandom_range(9);
    if (pick == 0)      wt = 16'h0000;
    else if (pick == 1) wt = 16'hFFFF;
    else                wt = 16'($urandom_range(65535));
    send_request(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 6'($urandom_range(63)), wt);
    counted = (cmd <= CMD_INIT);
  endtask

  // drop valid, then wait until every predicted phase has come out
  task automatic drain_phases();
    in_valid <= 1'b0;
    @(posedge clk);
    while (phases_outstanding != 0) @(posedge clk);
  endtask

  // writes all three registers on consecutive edges once the block is idle;
  // the upper byte of the pulse write is junk that must be dropped
  task automatic apply_settings(input logic [7:0] pulse, input logic [15:0] char_w,
                                input logic [15:0] cursor_w);
    drain_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ENABLE_PULSE;
    cfg_data  <= {8'($urandom_range(255)), pulse};
    @(posedge clk);
    cfg_index <= REG_CHAR_WAIT;
    cfg_data  <= char_w;
    @(posedge clk);
    cfg_index <= REG_CURSOR_WAIT;
    cfg_data  <= cursor_w;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input int items, input int pause_at);
    int counted_items;
    bit counted;
    counted_items = 0;
    while (counted_items < items) begin
      if (counted_items == pause_at)
        drain_phases();
      send_random_request(counted);
      if (counted)
        counted_items++;
    end
  endtask

  // receiver: random ready, and a long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_wanted) begin
        hold_off_wanted = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= rx_idle_on ? ($urandom_range(99) >= 16) : 1'b1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset register values
    send_request(CMD_NIBBLE, 8'hFF, 1'b0, 6'd0, 16'h0000);   // low bits only
    send_request(CMD_NIBBLE, 8'hA0, 1'b1, 6'd63, 16'hFFFF);  // high bits dropped
    send_request(CMD_BYTE, 8'h00, 1'b0, 6'd0, 16'h0000);
    send_request(CMD_BYTE, 8'hFF, 1'b1, 6'd63, 16'hFFFF);
    send_request(CMD_BYTE, 8'h5A, 1'b0, 6'd17, 16'd1234);
    send_request(CMD_CHAR, 8'h41, 1'b1, 6'd5, 16'($urandom_range(65535)));
    send_request(CMD_CHAR, 8'hFF, 1'b0, 6'd0, 16'hFFFF);
    send_request(CMD_CURSOR, 8'hFF, 1'b0, 6'd0, 16'hFFFF);   // unused fields ignored
    send_request(CMD_CURSOR, 8'h00, 1'b1, 6'd63, 16'h0000);
    send_request(CMD_INIT, 8'hFF, 1'b1, 6'd63, 16'hFFFF);
    // unused command codes give no phases at all
    send_request(3'd5, 8'($urandom_range(255)), 1'b1, 6'd63, 16'hFFFF);
    send_request(3'd6, 8'($urandom_range(255)), 1'b0, 6'd0, 16'h0000);
    send_request(3'd7, 8'hFF, 1'b1, 6'd63, 16'hFFFF);
    send_request(CMD_NIBBLE, 8'h05, 1'b0, 6'd0, 16'd7);

    // all registers at their lower extreme
    apply_settings(8'd0, 16'h0000, 16'h0000);
    send_request(CMD_NIBBLE, 8'h03, 1'b0, 6'd0, 16'h0000);
    send_request(CMD_CHAR, 8'h00, 1'b0, 6'd0, 16'h0000);
    send_request(CMD_CURSOR, 8'h00, 1'b1, 6'd21, 16'h0000);
    send_request(CMD_INIT, 8'h00, 1'b0, 6'd0, 16'h0000);

    // all registers at their upper extreme
    apply_settings(8'd255, 16'hFFFF, 16'hFFFF);
    send_request(CMD_BYTE, 8'hC3, 1'b0, 6'd0, 16'hFFFF);
    send_request(CMD_CHAR, 8'h7E, 1'b1, 6'd2, 16'd0);
    send_request(CMD_CURSOR, 8'h00, 1'b0, 6'd63, 16'h0000);
    send_request(CMD_INIT, 8'h00, 1'b0, 6'd0, 16'h0000);

    // random part, gaps on both sides
    apply_settings(8'($urandom_range(255)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
    random_phase(PHASE_ITEMS, -1);

    // a long stretch with no idling at all
    apply_settings(8'($urandom_range(255)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(PHASE_ITEMS, -1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // receiver holds off while the sender keeps offering, so the block
    // backs up and stalls its input
    apply_settings(8'($urandom_range(255)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
    hold_off_wanted = 1'b1;
    tx_idle_on = 1'b0;
    random_phase(PHASE_ITEMS, -1);
    tx_idle_on = 1'b1;

    // sender pauses half way until every phase is out
    apply_settings(ENABLE_PULSE_RST, CHAR_WAIT_RST, CURSOR_WAIT_RST);
    random_phase(PHASE_ITEMS, PHASE_ITEMS / 2);

    drain_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && phases_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/lcd4seq_pkg.sv
sv/lcd4seq_seq.sv
sv/lcd4seq_dp.sv
sv/char_lcd_four_bit_write_sequencer_core.sv
sim/lcd_phase_checker.sv
sim/tb.sv
